[rtl/core/frame_difference_scene_cut_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame difference scene cut detector.
// The macros expect clk, and FDSC_ASSERT also rst_n, to be visible in the using scope.
// ----------------------------------------------------------------------------
`ifndef FRAME_DIFFERENCE_SCENE_CUT_ASSERT_SVH
`define FRAME_DIFFERENCE_SCENE_CUT_ASSERT_SVH

// Checked only while out of reset.
`define FDSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FDSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/fdsc_pkg.sv]
// ----------------------------------------------------------------------------
// fdsc_pkg
// Shared widths, register indexes, codes and types of the scene cut detector.
// ----------------------------------------------------------------------------
package fdsc_pkg;

    localparam int PIX_W      = 8;
    localparam int COUNT_W    = 24;
    localparam int CFG_DATA_W = 22;
    localparam int CFG_IDX_W  = 1;
    localparam int THR_W      = 16;

    // Register indexes on the write port.
    localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Q8     = 1'd1;

    localparam logic [CFG_DATA_W-1:0] PIXELS_PER_FRAME_RST = 22'd76800;
    localparam logic [THR_W-1:0]      THRESHOLD_Q8_RST     = 16'd7680;

    // Input word actions.
    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_EOS   = 1'b1;

    // Result queue geometry.
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = 3;
    localparam int RES_CNT_W = 4;

    // Event handed from the accumulator to the decision stage.
    typedef struct packed {
        logic               valid;
        logic               eos;
        logic [COUNT_W-1:0] idx;
    } evt_t;

    typedef struct packed {
        logic [COUNT_W-1:0] boundary_frame;
        logic               is_final;
        logic               last_in_run;
    } result_t;

endpackage

[rtl/core/fdsc_if.sv]
// ----------------------------------------------------------------------------
// fdsc_if
// Valid/ready channels for pixel words in and boundary words out.
// ----------------------------------------------------------------------------
interface fdsc_in_if;
    import fdsc_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output action, output pixel_value, input ready);
    modport sink   (input valid, input action, input pixel_value, output ready);
endinterface

interface fdsc_out_if;
    import fdsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] boundary_frame;
    logic               is_final;
    logic               last_in_run;

    modport source (output valid, output boundary_frame, output is_final,
                    output last_in_run, input ready);
    modport sink   (input valid, input boundary_frame, input is_final,
                    input last_in_run, output ready);
endinterface

[rtl/core/fdsc_ram.sv]
// ----------------------------------------------------------------------------
// fdsc_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module fdsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2097152
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/fdsc_accum.sv]
// ----------------------------------------------------------------------------
// fdsc_accum
// Frame position tracking, frame memory read-modify-write and the running
// sum of absolute differences.
// ----------------------------------------------------------------------------
module fdsc_accum #(
    parameter int MAX_PIXELS = 2097152
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             accept,
    input  logic                                             action,
    input  logic [fdsc_pkg::PIX_W-1:0]                       pixel_value,
    input  logic [$clog2(MAX_PIXELS + 1)-1:0]                frame_size,
    output logic                                             s1_busy,
    output fdsc_pkg::evt_t                                   evt,
    output logic [$clog2(longint'(MAX_PIXELS) * 255 + 1)-1:0] evt_sum
);
    import fdsc_pkg::*;

    localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int NW = $clog2(MAX_PIXELS + 1);
    localparam int SW = $clog2(longint'(MAX_PIXELS) * 255 + 1);

    logic [PW-1:0]      pos_reg, pos_next;
    logic               refv_reg, refv_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               s1_valid_reg, s1_valid_next;

    logic               s1_eos_reg;
    logic               s1_acc_reg;
    logic               s1_end_reg;
    logic               s1_cmp_reg;
    logic [COUNT_W-1:0] s1_idx_reg;
    logic [PIX_W-1:0]   s1_pix_reg;

    logic [SW-1:0]      sum_reg, sum_next;
    evt_t               evt_reg, evt_next;
    logic [SW-1:0]      evt_sum_reg;

    logic               frame_end;
    logic               pix_accept;
    logic [PIX_W-1:0]   old_pix;
    logic [PIX_W-1:0]   diff;
    logic [SW-1:0]      total;

    assign pix_accept = accept && (action == ACTION_PIXEL);
    assign frame_end  = (NW'(pos_reg) + NW'(1)) >= frame_size;

    // Each position is read and rewritten in the same cycle; the RAM returns
    // the previous frame's pixel.
    fdsc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (pix_accept),
        .waddr (pos_reg),
        .wdata (pixel_value),
        .raddr (pos_reg),
        .rdata (old_pix)
    );

    // Accept stage: position, reference flag and comparison count.
    always_comb
    begin
        pos_next      = pos_reg;
        refv_next     = refv_reg;
        cnt_next      = cnt_reg;
        s1_valid_next = accept;
        if (accept)
        begin
            if (action == ACTION_EOS)
            begin
                pos_next  = '0;
                refv_next = 1'b0;
                cnt_next  = '0;
            end
            else if (frame_end)
            begin
                pos_next  = '0;
                refv_next = 1'b1;
                if (refv_reg)
                begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            refv_reg     <= 1'b0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            refv_reg     <= refv_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_eos_reg <= (action == ACTION_EOS);
            s1_acc_reg <= refv_reg;
            s1_end_reg <= frame_end;
            s1_cmp_reg <= (action == ACTION_PIXEL) && frame_end && refv_reg;
            s1_idx_reg <= cnt_reg;
            s1_pix_reg <= pixel_value;
        end
    end

    // Difference stage: accumulate and close the frame.
    assign diff  = (s1_pix_reg > old_pix) ? (s1_pix_reg - old_pix) : (old_pix - s1_pix_reg);
    assign total = sum_reg + (s1_acc_reg ? SW'(diff) : SW'(0));

    always_comb
    begin
        sum_next       = sum_reg;
        evt_next.valid = s1_valid_reg && (s1_eos_reg || s1_cmp_reg);
        evt_next.eos   = s1_eos_reg;
        evt_next.idx   = s1_idx_reg;
        if (s1_valid_reg)
        begin
            if (s1_eos_reg || s1_end_reg)
            begin
                sum_next = '0;
            end
            else
            begin
                sum_next = total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            evt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            evt_reg <= evt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_sum_reg <= total;
    end

    assign s1_busy = s1_valid_reg;
    assign evt     = evt_reg;
    assign evt_sum = evt_sum_reg;

endmodule

[rtl/core/fdsc_decide.sv]
// ----------------------------------------------------------------------------
// fdsc_decide
// Threshold compare at frame end and the queue of boundary words.
// ----------------------------------------------------------------------------
module fdsc_decide #(
    parameter int SW     = 29,
    parameter int PROD_W = 38
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdsc_pkg::evt_t                evt,
    input  logic [SW-1:0]                 evt_sum,
    input  logic [PROD_W-1:0]             prod,
    fdsc_out_if.source                    boundaries,
    output logic [fdsc_pkg::RES_CNT_W-1:0] occupancy
);
    import fdsc_pkg::*;

    localparam int CW = (SW + 8 > PROD_W) ? SW + 8 : PROD_W;

    result_t              res_q_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;

    logic [CW-1:0]        lhs, rhs;
    logic                 cut;
    logic [1:0]           n_push;
    result_t              r0, r1;
    logic                 pop;

    // Mean above threshold, evaluated exactly as sum * 256 > threshold * size.
    assign lhs = CW'({evt_sum, 8'h00});
    assign rhs = CW'(prod);
    assign cut = lhs > rhs;

    always_comb
    begin
        r0.boundary_frame = evt.idx;
        r0.is_final       = 1'b0;
        r0.last_in_run    = 1'b1;
        r1.boundary_frame = evt.idx;
        r1.is_final       = 1'b0;
        r1.last_in_run    = 1'b1;
        n_push            = 2'd0;
        if (evt.valid)
        begin
            if (evt.eos)
            begin
                r0.is_final = 1'b1;
                n_push      = 2'd1;
            end
            else if (evt.idx == '0)
            begin
                // The first comparison always opens a segment at zero.
                r0.last_in_run = !cut;
                n_push         = cut ? 2'd2 : 2'd1;
            end
            else
            begin
                n_push = cut ? 2'd1 : 2'd0;
            end
        end
    end

    assign pop = boundaries.valid && boundaries.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + (pop ? RES_PTR_W'(1) : RES_PTR_W'(0));
        cnt_next    = cnt_reg + RES_CNT_W'(n_push) - (pop ? RES_CNT_W'(1) : RES_CNT_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            res_q_reg[wr_ptr_reg] <= r0;
        end
        if (n_push == 2'd2)
        begin
            res_q_reg[wr_ptr_reg + RES_PTR_W'(1)] <= r1;
        end
    end

    assign boundaries.valid          = (cnt_reg != '0);
    assign boundaries.boundary_frame = res_q_reg[rd_ptr_reg].boundary_frame;
    assign boundaries.is_final       = res_q_reg[rd_ptr_reg].is_final;
    assign boundaries.last_in_run    = res_q_reg[rd_ptr_reg].last_in_run;
    assign occupancy                 = cnt_reg;

endmodule

[rtl/core/frame_difference_scene_cut.sv]
// ----------------------------------------------------------------------------
// frame_difference_scene_cut: mean absolute frame difference scene cut detector
// Throughput is one pixel word per cycle while the result queue has room, set by
// the single frame memory access (read old pixel, write new pixel) per accepted pixel.
// The last pixel of a frame or an end-of-stream word passes the accept stage and event
// registers into the boundary queue; reset clears control state, not the frame memory.
// ----------------------------------------------------------------------------
`include "frame_difference_scene_cut_assert.svh"

module frame_difference_scene_cut #(
    parameter int MAX_PIXELS = 2097152
) (
    input  logic                              clk,
    input  logic                              rst_n,
    fdsc_in_if.sink                           pixels,
    fdsc_out_if.source                        boundaries,
    input  logic                              wr_en,
    input  logic [fdsc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [fdsc_pkg::CFG_DATA_W-1:0]   wr_data
);
    import fdsc_pkg::*;

    // Widths of the frame size, the difference sum and the threshold product.
    localparam int NW     = $clog2(MAX_PIXELS + 1);
    localparam int SW     = $clog2(longint'(MAX_PIXELS) * 255 + 1);
    localparam int PROD_W = THR_W + NW;

    logic [CFG_DATA_W-1:0] ppf_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [NW-1:0]         frame_size;
    logic [PROD_W-1:0]     prod_reg;

    logic                  accept;
    logic                  s1_busy;
    evt_t                  evt;
    logic [SW-1:0]         evt_sum;
    logic [RES_CNT_W-1:0]  occupancy;
    logic [RES_CNT_W:0]    reserved;

    // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppf_reg <= PIXELS_PER_FRAME_RST;
            thr_reg <= THRESHOLD_Q8_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PIXELS_PER_FRAME: ppf_reg <= wr_data;
                REG_THRESHOLD_Q8:     thr_reg <= wr_data[THR_W-1:0];
                default:              ;
            endcase
        end
    end

    // A frame size of zero acts as one; sizes past the memory saturate.
    always_comb
    begin
        if (ppf_reg == '0)
        begin
            frame_size = NW'(1);
        end
        else if (32'(ppf_reg) > 32'(MAX_PIXELS))
        begin
            frame_size = NW'(MAX_PIXELS);
        end
        else
        begin
            frame_size = NW'(ppf_reg);
        end
    end

    // The right-hand side of the cut test depends on configuration only, so it
    // is computed ahead and held in a register.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(thr_reg) * PROD_W'(frame_size);
    end

    // Every item in flight may still produce two words, so space for two is
    // held back for each of them and for the word about to be accepted.
    assign reserved = (RES_CNT_W + 1)'(occupancy)
                    + (s1_busy   ? (RES_CNT_W + 1)'(2) : (RES_CNT_W + 1)'(0))
                    + (evt.valid ? (RES_CNT_W + 1)'(2) : (RES_CNT_W + 1)'(0));

    assign pixels.ready = reserved <= (RES_CNT_W + 1)'(RES_DEPTH - 2);
    assign accept       = pixels.valid && pixels.ready;

    fdsc_accum #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (pixels.action),
        .pixel_value (pixels.pixel_value),
        .frame_size  (frame_size),
        .s1_busy     (s1_busy),
        .evt         (evt),
        .evt_sum     (evt_sum)
    );

    fdsc_decide #(
        .SW     (SW),
        .PROD_W (PROD_W)
    ) u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .evt_sum    (evt_sum),
        .prod       (prod_reg),
        .boundaries (boundaries),
        .occupancy  (occupancy)
    );

    // A frame-end event must always find room for both of its words.
    `FDSC_ASSERT(a_credit_room, evt.valid |-> (occupancy <= RES_CNT_W'(RES_DEPTH - 2)), "result queue lacks room for an event")
    // An end-of-stream word reaches the decision stage through the accept stage registers and the event register.
    `FDSC_ASSERT(a_eos_latency, (accept && (pixels.action == ACTION_EOS)) |-> ##2 (evt.valid && evt.eos), "end of stream lost in the pipeline")
    // The queue count never passes its depth.
    `FDSC_ASSERT_ALWAYS(a_queue_bound, occupancy <= RES_CNT_W'(RES_DEPTH), "result queue overflow")

endmodule

[dv/frame_difference_scene_cut_tb.sv]
// ----------------------------------------------------------------------------
// frame_difference_scene_cut_tb: self-checking bench for the scene cut detector
// Drives pixel and end-of-stream words through the input channel. A scoreboard
// object mirrors the frame memory, the running difference sum and the cut
// decision, and compares every boundary word with the oldest predicted one.
// The stimulus is a directed opening, a back-pressure burst and a long
// random part of similar or changed frames, with random idling on both sides.
// ----------------------------------------------------------------------------
module frame_difference_scene_cut_tb;
    import fdsc_pkg::*;

    localparam int          MAX_PIXELS    = 2097152;
    localparam int          ITEM_TARGET   = 1050;
    // The last word of a frame passes the accept stage and event registers before its first
    // boundary word; allow a good margin before touching the registers.
    localparam int          SETTLE_CYCLES = 12;
    localparam int          LONG_HOLD     = 300;
    localparam int unsigned LIMIT_CYCLES  = 500000;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the stored frame and of the per-run
    // counters, predicts the boundary words of each accepted input word and
    // checks each accepted boundary word against the oldest prediction.
    // ------------------------------------------------------------------------
    class cut_scoreboard;
        bit [PIX_W-1:0]      stored_pixels [int unsigned];
        int unsigned         pixel_index;
        longint unsigned     abs_diff_total;
        bit                  have_reference;
        bit [COUNT_W-1:0]    comparisons;
        bit [CFG_DATA_W-1:0] frame_reg;
        bit [THR_W-1:0]      threshold_reg;
        result_t             expected_boundaries [$];
        int unsigned         errors;

        function new();
            frame_reg     = PIXELS_PER_FRAME_RST;
            threshold_reg = THRESHOLD_Q8_RST;
            errors        = 0;
            clear_run();
        endfunction

        function void clear_run();
            pixel_index    = 0;
            abs_diff_total = 0;
            have_reference = 1'b0;
            comparisons    = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_PIXELS_PER_FRAME)
                frame_reg = data;
            else if (idx == REG_THRESHOLD_Q8)
                threshold_reg = data[THR_W-1:0];
        endfunction

        function int unsigned pending();
            return expected_boundaries.size();
        endfunction

        function void add_boundary(bit [COUNT_W-1:0] idx, bit fin, bit last);
            result_t r;
            r.boundary_frame    = idx;
            r.is_final          = fin;
            r.last_in_run       = last;
            expected_boundaries = {expected_boundaries, r};
        endfunction

        function void note_word(logic act, logic [PIX_W-1:0] value);
            int unsigned    frame_len;
            int unsigned    pos;
            bit [PIX_W-1:0] old_px;
            bit             cut;
            if (act == ACTION_EOS)
            begin
                add_boundary(comparisons, 1'b1, 1'b1);
                clear_run();
                return;
            end
            // A zero frame size acts as one pixel; oversized values saturate.
            if (frame_reg == 0)
                frame_len = 1;
            else if (frame_reg > MAX_PIXELS)
                frame_len = MAX_PIXELS;
            else
                frame_len = frame_reg;
            pos = pixel_index;
            if (pos < MAX_PIXELS)
            begin
                if (have_reference)
                begin
                    old_px = stored_pixels.exists(pos) ? stored_pixels[pos] : '0;
                    abs_diff_total += (value > old_px) ? value - old_px : old_px - value;
                end
                stored_pixels[pos] = value;
            end
            // A shrunken frame size ends the frame at the first pixel at or past it.
            if (pos + 1 < frame_len)
            begin
                pixel_index = pos + 1;
                return;
            end
            if (!have_reference)
            begin
                have_reference = 1'b1;
            end
            else
            begin
                cut = (abs_diff_total * 256) > (longint'(threshold_reg) * frame_len);
                if (comparisons == 0)
                    add_boundary('0, 1'b0, !cut);
                if (cut)
                    add_boundary(comparisons, 1'b0, 1'b1);
                comparisons = comparisons + 1'b1;
            end
            pixel_index    = 0;
            abs_diff_total = 0;
        endfunction

        function void check_boundary(result_t got);
            result_t want;
            if (expected_boundaries.size() == 0)
            begin
                $error("boundary word with nothing predicted: boundary_frame %0d",
                       got.boundary_frame);
                errors++;
                return;
            end
            want = expected_boundaries.pop_front();
            if (got.boundary_frame !== want.boundary_frame)
            begin
                $error("boundary_frame: expected %0d, actual %0d",
                       want.boundary_frame, got.boundary_frame);
                errors++;
            end
            if (got.is_final !== want.is_final)
            begin
                $error("is_final: expected %0b, actual %0b", want.is_final, got.is_final);
                errors++;
            end
            if (got.last_in_run !== want.last_in_run)
            begin
                $error("last_in_run: expected %0b, actual %0b",
                       want.last_in_run, got.last_in_run);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    fdsc_in_if  pixel_words ();
    fdsc_out_if boundary_words ();

    cut_scoreboard board = new();

    // Idling state of each side: while calm, a side never waits.
    bit          send_calm;
    bit          recv_calm;
    // Raised by the stimulus to make the receiver hold off for a long stretch.
    bit          long_hold_req;
    int unsigned words_sent;

    frame_difference_scene_cut #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixel_words),
        .boundaries (boundary_words),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a word.
    initial
    begin
        #(LIMIT_CYCLES * 4);
        $display("frame_difference_scene_cut verification failed");
        $finish;
    end

    // Both monitors sample at the clock edge, before any driver update lands.
    always @(posedge clk)
    begin
        if (rst_n && pixel_words.valid && pixel_words.ready)
            board.note_word(pixel_words.action, pixel_words.pixel_value);
        if (rst_n && boundary_words.valid && boundary_words.ready)
            board.check_boundary(result_t'({boundary_words.boundary_frame,
                                            boundary_words.is_final,
                                            boundary_words.last_in_run}));
    end

    // Receiver: draws a wait before every boundary word, and once in the run
    // drops ready for a long stretch so the result queue fills and the input
    // channel has to stall.
    initial
    begin : boundary_sink
        int unsigned gap;
        boundary_words.ready <= 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                gap           = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_calm = !recv_calm;
                gap = recv_calm ? 0 : $urandom_range(0, 15);
            end
            if (gap != 0)
            begin
                boundary_words.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                boundary_words.ready <= 1'b1;
            end
            do @(posedge clk); while (!(boundary_words.valid && boundary_words.ready));
        end
    end

    // Offers one word after a random gap and returns once it has been taken.
    // Valid stays high on return, so a word sent right after follows it back to back.
    task automatic send_word(input logic act, input logic [PIX_W-1:0] value);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            pixel_words.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_words.valid       <= 1'b1;
        pixel_words.action      <= act;
        pixel_words.pixel_value <= value;
        do @(posedge clk); while (!pixel_words.ready);
        words_sent++;
    endtask

    task automatic send_frame(input bit [PIX_W-1:0] px [$]);
        foreach (px[i])
            send_word(ACTION_PIXEL, px[i]);
    endtask

    // The pixel value of an end-of-stream word is ignored, so it carries noise.
    task automatic send_eos();
        send_word(ACTION_EOS, PIX_W'($urandom));
    endtask

    // Brings the block to rest: waits until the last accepted word has been noted and
    // every predicted word is out, then waits out the settle margin, since the last
    // pixels of a partial frame cause no word at all.
    task automatic settle();
        pixel_words.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= CFG_DATA_W'(value);
        board.write_reg(idx, CFG_DATA_W'(value));
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    // One random run: a setting, a few frames that either resemble the
    // previous one or change completely, and an end-of-stream word. Now and
    // then the run is cut short inside a frame.
    task automatic random_run();
        int unsigned    pick;
        int unsigned    len;
        int unsigned    frame_len;
        int unsigned    frames;
        int unsigned    amp;
        int unsigned    part_len;
        int             v;
        bit [PIX_W-1:0] img [];
        settle();
        pick = $urandom_range(0, 19);
        case ($urandom_range(0, 5))
            0:       write_reg(REG_THRESHOLD_Q8, 0);
            1:       write_reg(REG_THRESHOLD_Q8, 65535);
            2:       write_reg(REG_THRESHOLD_Q8, $urandom_range(0, 65535));
            3, 4:    write_reg(REG_THRESHOLD_Q8, $urandom_range(0, 40 * 256));
            default: ;
        endcase
        if (pick == 18)
        begin
            // A size past the frame memory saturates; only a partial frame follows.
            write_reg(REG_PIXELS_PER_FRAME, $urandom_range(MAX_PIXELS + 1, 4194303));
            repeat ($urandom_range(1, 6))
                send_word(ACTION_PIXEL, PIX_W'($urandom));
            send_eos();
            return;
        end
        if (pick == 0)
            len = 0;
        else if (pick < 4)
            len = 1;
        else if (pick == 19)
            len = $urandom_range(33, 96);
        else
            len = $urandom_range(2, 12);
        write_reg(REG_PIXELS_PER_FRAME, len);
        frame_len = (len == 0) ? 1 : len;
        frames    = (frame_len > 32) ? 2 : $urandom_range(1, 8);
        img       = new[frame_len];
        for (int f = 0; f <= frames; f++)
        begin
            if (f == 0 || $urandom_range(0, 3) == 0)
            begin
                foreach (img[i])
                    img[i] = PIX_W'($urandom);
            end
            else
            begin
                amp = $urandom_range(0, 40);
                foreach (img[i])
                begin
                    v = int'(img[i]) + int'($urandom_range(0, 2 * amp)) - int'(amp);
                    img[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : PIX_W'(v);
                end
            end
            if (f > 0 && $urandom_range(0, 29) == 0)
            begin
                // Broken run: end of stream part way through a frame.
                part_len = $urandom_range(0, frame_len - 1);
                for (int i = 0; i < part_len; i++)
                    send_word(ACTION_PIXEL, img[i]);
                break;
            end
            foreach (img[i])
                send_word(ACTION_PIXEL, img[i]);
        end
        send_eos();
    endtask

    initial
    begin : stimulus
        bit [PIX_W-1:0] last_px;
        rst_n                   <= 1'b0;
        wr_en                   <= 1'b0;
        wr_index                <= REG_PIXELS_PER_FRAME;
        wr_data                 <= '0;
        pixel_words.valid       <= 1'b0;
        pixel_words.action      <= ACTION_PIXEL;
        pixel_words.pixel_value <= '0;
        send_calm     = 1'b0;
        recv_calm     = 1'b0;
        long_hold_req = 1'b0;
        words_sent    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a partial first frame is dropped, the count is zero.
        send_frame('{8'd0, 8'd255});
        send_eos();

        // A zero frame size acts as one pixel. With a zero threshold any change
        // is a cut; the first comparison with a cut gives two words for
        // boundary 0, a still frame gives none, and the end reports three.
        settle();
        write_reg(REG_PIXELS_PER_FRAME, 0);
        write_reg(REG_THRESHOLD_Q8, 0);
        send_frame('{8'd255, 8'd0, 8'd0, 8'd255});
        send_eos();

        // Threshold 1.0 on two-pixel frames: a mean of exactly 1.0 is no cut,
        // a mean of 1.5 is.
        settle();
        write_reg(REG_PIXELS_PER_FRAME, 2);
        write_reg(REG_THRESHOLD_Q8, 256);
        send_frame('{8'd10, 8'd20, 8'd11, 8'd19, 8'd13, 8'd20});
        send_eos();

        // Largest threshold never cuts. The frame size shrinks in the middle
        // of a frame, so the next pixel ends it.
        settle();
        write_reg(REG_PIXELS_PER_FRAME, 4);
        write_reg(REG_THRESHOLD_Q8, 65535);
        send_frame('{8'd1, 8'd2, 8'd3, 8'd4, 8'd200, 8'd0});
        settle();
        write_reg(REG_PIXELS_PER_FRAME, 2);
        send_frame('{8'd255});
        send_eos();

        // Largest register value saturates to the memory size.
        settle();
        write_reg(REG_PIXELS_PER_FRAME, 4194303);
        send_frame('{8'd128, 8'd127});
        send_eos();

        // Back pressure: one-pixel frames that all cut produce a word per pixel
        // while the receiver holds off, so the block must stall its input.
        settle();
        write_reg(REG_PIXELS_PER_FRAME, 1);
        write_reg(REG_THRESHOLD_Q8, 0);
        long_hold_req = 1'b1;
        last_px       = PIX_W'($urandom);
        repeat (40)
        begin
            last_px = last_px ^ PIX_W'($urandom_range(1, 255));
            send_word(ACTION_PIXEL, last_px);
        end
        send_eos();

        while (words_sent < ITEM_TARGET)
            random_run();

        settle();
        if (board.errors == 0 && board.pending() == 0)
            $display("frame_difference_scene_cut verification clean");
        else
            $display("frame_difference_scene_cut verification failed");
        $finish;
    end
endmodule
